[src/dpc_pkg.sv]
// Package for the disk placement checker: item and entry types, codes and
// default sizes. Used by every module of the block.
`default_nettype none

package dpc_pkg;

  localparam int unsigned MAX_CIRCLES_DEF = 256;
  localparam int unsigned FRAC_BITS_DEF   = 8;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned RADIUS_W = 20;
  localparam int unsigned PERIOD_W = 15;
  localparam int unsigned OUTCNT_W = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // drain length: ST_DRAIN counts from zero up to this value, by which time the hit flag of the last entry is visible
  localparam int unsigned DIST_LAT = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WALL_BOTTOM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_X    = 2'd3;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    RSN_NONE    = 2'd0,
    RSN_BOTTOM  = 2'd1,
    RSN_TOP     = 2'd2,
    RSN_OVERLAP = 2'd3
  } reason_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALL,
    ST_SWEEP,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic signed [COORD_W-1:0]  center_x;
    logic signed [COORD_W-1:0]  center_y;
    logic [RADIUS_W-1:0]        disk_radius;
    logic                       radius_given;
  } in_item_t;

  typedef struct packed {
    logic                placement_ok;
    logic [1:0]          fail_reason;
    logic                table_full;
    logic [OUTCNT_W-1:0] circle_count;
  } out_item_t;

  // one stored circle
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RADIUS_W-1:0]       radius;
    logic                      radius_valid;
  } entry_t;

  // chain control: shift in at the front, or rotate towards the head
  typedef struct packed {
    logic ins;
    logic rot;
  } chain_ctrl_t;

endpackage

`default_nettype wire

[src/dpc_cell.sv]
// One cell of the circle chain: holds a single stored circle.
// Depends on dpc_pkg for the entry and control types.
`default_nettype none

module dpc_cell (
  input  wire logic                 clk_i,
  input  wire dpc_pkg::chain_ctrl_t ctrl_i,
  input  wire dpc_pkg::entry_t      prev_i,
  input  wire dpc_pkg::entry_t      next_i,
  output dpc_pkg::entry_t           entry_o
);

  dpc_pkg::entry_t entry_q;

  // insert pushes towards the tail, rotation pulls towards the head
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins) begin
      entry_q <= prev_i;
    end else if (ctrl_i.rot) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[src/dpc_dist.sv]
// Pipelined distance unit: tests one stored circle a cycle against the query
// disk and keeps a sticky overlap flag. Depends on dpc_pkg.
`default_nettype none

module dpc_dist #(
  parameter int unsigned FRAC_BITS = dpc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                clr_i,
  input  wire logic                                valid_i,
  input  wire dpc_pkg::entry_t                     entry_i,
  input  wire logic signed [dpc_pkg::COORD_W-1:0]  cx_i,
  input  wire logic signed [dpc_pkg::COORD_W-1:0]  cy_i,
  input  wire logic [dpc_pkg::RADIUS_W-1:0]        r_i,
  input  wire logic [dpc_pkg::RADIUS_W-1:0]        gap_i,
  input  wire logic [dpc_pkg::PERIOD_W-1:0]        period_i,
  output logic                                     hit_o
);

  localparam int unsigned LEN_W = dpc_pkg::PERIOD_W + FRAC_BITS;
  localparam int unsigned DX_W  = (LEN_W + 2 > 26) ? LEN_W + 2 : 26;
  localparam int unsigned MAG_W = DX_W - 1;
  localparam int unsigned SQ_W  = 2 * MAG_W + 1;
  localparam int unsigned DY_W  = dpc_pkg::COORD_W + 1;
  localparam int unsigned LIM_W = dpc_pkg::RADIUS_W + 2;

  logic [LEN_W-1:0] len;
  assign len = LEN_W'(period_i) << FRAC_BITS;

  // stage 1: differences and contact limit (radius sum plus gap)
  logic signed [DX_W-1:0] dx_d, dx_q;
  logic signed [DY_W-1:0] dy_d, dy_q;
  logic [dpc_pkg::RADIUS_W-1:0] re;
  logic [LIM_W-1:0] lim_d, lim_q;
  logic v1_q;

  assign dx_d  = DX_W'(cx_i) - DX_W'(entry_i.x);
  assign dy_d  = DY_W'(cy_i) - DY_W'(entry_i.y);
  assign re    = entry_i.radius_valid ? entry_i.radius : r_i;
  assign lim_d = LIM_W'(r_i) + LIM_W'(re) + LIM_W'(gap_i);

  // stage 2: single wrap, |dy|
  logic signed [DX_W:0]   two_dx, lens;
  logic signed [DX_W-1:0] lenw;
  logic signed [DX_W-1:0] dxf_d, dxf_q;
  logic [dpc_pkg::COORD_W-1:0] ay_d, ay_q;
  logic [LIM_W-1:0] lim2_q;
  logic v2_q;

  assign two_dx = signed'({dx_q, 1'b0});
  assign lens   = signed'((DX_W + 1)'(len));
  assign lenw   = signed'(DX_W'(len));

  always_comb begin
    dxf_d = dx_q;
    if (period_i != '0) begin
      if (two_dx > lens) begin
        dxf_d = dx_q - lenw;
      end else if (two_dx < -lens) begin
        dxf_d = dx_q + lenw;
      end
    end
  end

  assign ay_d = dy_q[DY_W-1] ? dpc_pkg::COORD_W'(-dy_q) : dpc_pkg::COORD_W'(dy_q);

  // stage 3: squares
  logic [MAG_W-1:0] ax;
  logic [2*MAG_W-1:0] axsq_d, axsq_q;
  logic [2*dpc_pkg::COORD_W-1:0] aysq_d, aysq_q;
  logic [2*LIM_W-1:0] limsq_d, limsq_q;
  logic v3_q;

  assign ax      = dxf_q[DX_W-1] ? MAG_W'(-dxf_q) : MAG_W'(dxf_q);
  assign axsq_d  = ax * ax;
  assign aysq_d  = ay_q * ay_q;
  assign limsq_d = lim2_q * lim2_q;

  // stage 4: sum and compare
  logic [SQ_W-1:0] d2;
  logic hit_d, hit_q;

  assign d2    = SQ_W'(axsq_q) + SQ_W'(aysq_q);
  assign hit_d = v3_q && (d2 < SQ_W'(limsq_q));

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    lim_q   <= lim_d;
    dxf_q   <= dxf_d;
    ay_q    <= ay_d;
    lim2_q  <= lim_q;
    axsq_q  <= axsq_d;
    aysq_q  <= aysq_d;
    limsq_q <= limsq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (clr_i) begin
        hit_q <= 1'b0;
      end else if (hit_d) begin
        hit_q <= 1'b1;
      end
    end
  end

  assign hit_o = hit_q;

endmodule

`default_nettype wire

[src/disk_placement_checker_core.sv]
// Top level of the disk placement checker: control sequencer, circle chain
// and distance unit. Depends on dpc_pkg, dpc_cell and dpc_dist.
`default_nettype none

// Channel   Dir  Handshake               Payload
// -------   ---  ---------------------   -------------------------------
// in        in   in_valid_i/in_stall_o   dpc_pkg::in_item_t  in_data_i
// out       out  out_valid_o/out_stall_i dpc_pkg::out_item_t out_data_o
// cfg       in   cfg_we_i (no wait)      cfg_idx_i, cfg_wdata_i
//
// Query: states WALL, SWEEP, DRAIN and OUT when both walls pass, WALL and
//   OUT when a wall fails. The chain rotates once fully past the
//   single distance unit at its head, one circle a cycle.
// Insert, clear and the unused opcode go straight to OUT.
// One item at a time; the result register lets a new transfer in while the
//   previous result is still stalled.
// Reset empties the table (count to zero); cell contents are not cleared.

module disk_placement_checker_core #(
  parameter int unsigned MAX_CIRCLES = dpc_pkg::MAX_CIRCLES_DEF,
  parameter int unsigned FRAC_BITS   = dpc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire dpc_pkg::in_item_t                 in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output dpc_pkg::out_item_t                     out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [dpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [dpc_pkg::COORD_W-1:0]       cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(MAX_CIRCLES + 1);
  localparam int unsigned DRN_W = $clog2(dpc_pkg::DIST_LAT + 1);
  localparam int unsigned WALL_W = dpc_pkg::COORD_W + 2;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic signed [dpc_pkg::COORD_W-1:0] wall_bot_q, wall_top_q;
  logic [dpc_pkg::RADIUS_W-1:0]       gap_q;
  logic [dpc_pkg::PERIOD_W-1:0]       period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_bot_q <= '0;
      wall_top_q <= '0;
      gap_q      <= '0;
      period_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dpc_pkg::REG_WALL_BOTTOM: wall_bot_q <= signed'(cfg_wdata_i);
        dpc_pkg::REG_WALL_TOP:    wall_top_q <= signed'(cfg_wdata_i);
        dpc_pkg::REG_GAP_MIN:     gap_q      <= cfg_wdata_i[dpc_pkg::RADIUS_W-1:0];
        dpc_pkg::REG_PERIOD_X:    period_q   <= cfg_wdata_i[dpc_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // sequencer state
  // ---------------------------------------------------------------------
  dpc_pkg::state_e    state_q, state_d;
  dpc_pkg::in_item_t  item_q, item_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   sweep_q, sweep_d;
  logic [DRN_W-1:0]   drain_q, drain_d;
  logic               full_q, full_d;
  dpc_pkg::reason_e   reason_q, reason_d;
  logic               out_valid_q, out_valid_d;
  dpc_pkg::out_item_t out_q, out_d;

  logic in_xfer;
  logic out_free;
  logic do_insert;
  logic dist_clr;
  logic dist_valid;
  logic hit;

  dpc_pkg::chain_ctrl_t chain_ctrl;
  dpc_pkg::entry_t      new_entry;
  dpc_pkg::entry_t      cells [MAX_CIRCLES];

  // wall tests on the held query
  logic signed [WALL_W-1:0] low_edge, high_edge, bot_lim, top_lim;
  logic fail_bot, fail_top;

  assign low_edge  = WALL_W'(item_q.center_y) - signed'(WALL_W'(item_q.disk_radius));
  assign high_edge = WALL_W'(item_q.center_y) + signed'(WALL_W'(item_q.disk_radius));
  assign bot_lim   = WALL_W'(wall_bot_q) + signed'(WALL_W'(gap_q));
  assign top_lim   = WALL_W'(wall_top_q) - signed'(WALL_W'(gap_q));
  assign fail_bot  = low_edge < bot_lim;
  assign fail_top  = high_edge > top_lim;

  // count as seen on the port, wrapped to its field width
  logic [CNT_W+dpc_pkg::OUTCNT_W-1:0] count_ext;
  assign count_ext = (CNT_W + dpc_pkg::OUTCNT_W)'(count_q);

  assign in_stall_o = (state_q != dpc_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign do_insert  = in_xfer && (in_data_i.opcode == dpc_pkg::OP_INSERT)
                      && (count_q < CNT_W'(MAX_CIRCLES));

  assign new_entry.x            = in_data_i.center_x;
  assign new_entry.y            = in_data_i.center_y;
  assign new_entry.radius       = in_data_i.disk_radius;
  assign new_entry.radius_valid = in_data_i.radius_given;

  assign chain_ctrl.ins = do_insert;
  assign chain_ctrl.rot = (state_q == dpc_pkg::ST_SWEEP);

  // only the head cell's entry is tested; it is live when its slot is in use
  assign dist_valid = (state_q == dpc_pkg::ST_SWEEP) && (sweep_q < count_q);
  assign dist_clr   = (state_q == dpc_pkg::ST_WALL);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    count_d     = count_q;
    sweep_d     = sweep_q;
    drain_d     = drain_q;
    full_d      = full_q;
    reason_d    = reason_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      dpc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          item_d   = in_data_i;
          full_d   = 1'b0;
          reason_d = dpc_pkg::RSN_NONE;
          state_d  = dpc_pkg::ST_OUT;
          case (in_data_i.opcode)
            dpc_pkg::OP_QUERY: begin
              state_d = dpc_pkg::ST_WALL;
            end
            dpc_pkg::OP_INSERT: begin
              if (do_insert) begin
                count_d = count_q + 1'b1;
              end else begin
                full_d = 1'b1;
              end
            end
            dpc_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      dpc_pkg::ST_WALL: begin
        sweep_d = '0;
        if (fail_bot) begin
          reason_d = dpc_pkg::RSN_BOTTOM;
          state_d  = dpc_pkg::ST_OUT;
        end else if (fail_top) begin
          reason_d = dpc_pkg::RSN_TOP;
          state_d  = dpc_pkg::ST_OUT;
        end else begin
          state_d = dpc_pkg::ST_SWEEP;
        end
      end
      dpc_pkg::ST_SWEEP: begin
        sweep_d = sweep_q + 1'b1;
        drain_d = '0;
        if (sweep_q == CNT_W'(MAX_CIRCLES - 1)) begin
          state_d = dpc_pkg::ST_DRAIN;
        end
      end
      dpc_pkg::ST_DRAIN: begin
        drain_d = drain_q + 1'b1;
        if (drain_q == DRN_W'(dpc_pkg::DIST_LAT)) begin
          reason_d = hit ? dpc_pkg::RSN_OVERLAP : dpc_pkg::RSN_NONE;
          state_d  = dpc_pkg::ST_OUT;
        end
      end
      dpc_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.placement_ok = (item_q.opcode == dpc_pkg::OP_QUERY)
                               && (reason_q == dpc_pkg::RSN_NONE);
          out_d.fail_reason  = reason_q;
          out_d.table_full   = full_q;
          out_d.circle_count = count_ext[dpc_pkg::OUTCNT_W-1:0];
          state_d            = dpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpc_pkg::ST_IDLE;
      count_q     <= '0;
      sweep_q     <= '0;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sweep_q     <= sweep_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    full_q   <= full_d;
    reason_q <= reason_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // circle chain: slot 0 is the head, newest entry goes in at slot 0.
  // A full rotation of MAX_CIRCLES steps brings every entry back home.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < MAX_CIRCLES; i++) begin : g_cell
    dpc_pkg::entry_t prev_e, next_e;

    if (i == 0) begin : g_head
      assign prev_e = new_entry;
    end else begin : g_body
      assign prev_e = cells[i-1];
    end

    if (i == MAX_CIRCLES - 1) begin : g_tail
      assign next_e = cells[0];
    end else begin : g_link
      assign next_e = cells[i+1];
    end

    dpc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (chain_ctrl),
      .prev_i  (prev_e),
      .next_i  (next_e),
      .entry_o (cells[i])
    );
  end

  dpc_dist #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (dist_clr),
    .valid_i  (dist_valid),
    .entry_i  (cells[0]),
    .cx_i     (item_q.center_x),
    .cy_i     (item_q.center_y),
    .r_i      (item_q.disk_radius),
    .gap_i    (gap_q),
    .period_i (period_q),
    .hit_o    (hit)
  );

endmodule

`default_nettype wire

[bench/tb_disk_placement_checker_core.sv]
// Self-checking bench for disk_placement_checker_core: directed and random
// inserts, clears and queries, checked against an in-bench circle table.
// Depends on dpc_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_disk_placement_checker_core;

  localparam int unsigned TB_CIRCLES = dpc_pkg::MAX_CIRCLES_DEF;
  localparam int unsigned FRAC = dpc_pkg::FRAC_BITS_DEF;
  // opcode 3 is not in the enum; the block must treat it as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // every query that passes the walls sweeps the whole chain; allow a wide margin for stalls
  localparam int QUIET_LIMIT = 4000;
  localparam int END_WAIT = 300;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // block inputs, all known from time zero
  logic                          in_valid = 1'b0;
  dpc_pkg::in_item_t             in_data = '0;
  logic                          out_stall = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [dpc_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [dpc_pkg::COORD_W-1:0]   cfg_wdata = '0;
  logic                          in_stall;
  logic                          out_valid;
  dpc_pkg::out_item_t            out_data;

  disk_placement_checker_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // --------------------------------------------------------------------
  // Bench copy of the circle table and registers. Updated on every input
  // transfer, so the expected outcome is known the moment the item is taken.
  // --------------------------------------------------------------------
  dpc_pkg::entry_t circle_bank [TB_CIRCLES];
  int     circle_total = 0;
  longint cfg_bottom = 0;
  longint cfg_top    = 0;
  longint cfg_gap    = 0;
  longint cfg_period = 0;

  dpc_pkg::in_item_t  pending_items [$];  // waiting for the driver
  dpc_pkg::out_item_t outcome_q [$];      // outcomes still owed by the block

  bit in_fire = 1'b0;            // input transfer at the last rising edge
  bit steady = 1'b0;             // suppresses idling on both sides
  int fault_count = 0;
  int quiet_cycles = 0;

  // last well-formed insert, used to aim probes right at the contact distance
  int last_x = 0, last_y = 0, last_r = 0;
  bit last_given = 1'b0;

  // Wall tests first, then every stored circle in order. Squared distances
  // are compared against the squared contact limit; touching is allowed.
  function automatic dpc_pkg::reason_e judge_query(longint cx, longint cy, longint r);
    longint len, dx, dy, re, lim;
    int     i;
    if (cy - r < cfg_bottom + cfg_gap) return dpc_pkg::RSN_BOTTOM;
    if (cy + r > cfg_top - cfg_gap) return dpc_pkg::RSN_TOP;
    for (i = 0; i < circle_total; i++) begin
      re = circle_bank[i].radius_valid ? longint'(circle_bank[i].radius) : r;
      dx = cx - longint'($signed(circle_bank[i].x));
      // minimum image, folded once only; a wide dx stays as it is
      if (cfg_period != 0) begin
        len = cfg_period << FRAC;
        if (2 * dx > len) dx -= len;
        if (2 * dx < -len) dx += len;
      end
      dy = cy - longint'($signed(circle_bank[i].y));
      lim = r + re + cfg_gap;
      if (dx * dx + dy * dy < lim * lim) return dpc_pkg::RSN_OVERLAP;
    end
    return dpc_pkg::RSN_NONE;
  endfunction

  function automatic dpc_pkg::out_item_t placement_outcome(dpc_pkg::in_item_t it);
    dpc_pkg::out_item_t res;
    dpc_pkg::reason_e   why;
    res = '0;
    case (it.opcode)
      dpc_pkg::OP_QUERY: begin
        why = judge_query(longint'($signed(it.center_x)), longint'($signed(it.center_y)),
                          longint'(it.disk_radius));
        res.fail_reason  = why;
        res.placement_ok = (why == dpc_pkg::RSN_NONE);
      end
      dpc_pkg::OP_INSERT: begin
        if (circle_total >= TB_CIRCLES) begin
          res.table_full = 1'b1;  // dropped, table unchanged
        end else begin
          circle_bank[circle_total].x            = it.center_x;
          circle_bank[circle_total].y            = it.center_y;
          circle_bank[circle_total].radius       = it.disk_radius;
          circle_bank[circle_total].radius_valid = it.radius_given;
          circle_total++;
        end
      end
      dpc_pkg::OP_CLEAR: circle_total = 0;  // contents stay, only the count drops
      default: ;
    endcase
    res.circle_count = dpc_pkg::OUTCNT_W'(circle_total);
    return res;
  endfunction

  // --------------------------------------------------------------------
  // Driver: presents the next pending item once the previous one has been
  // taken; the payload holds still while stalled.
  // --------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, independent of out_valid
  always @(negedge clk) begin
    out_stall <= rst_n && !steady && ($urandom_range(0, 99) < 33);
  end

  task automatic report_fault(string what, dpc_pkg::out_item_t want,
                              dpc_pkg::out_item_t got);
    fault_count++;
    if (fault_count <= 10) begin
      $write("%0t %s: want ok=%0d reason=%0d full=%0d count=%0d,", $realtime, what,
             want.placement_ok, want.fail_reason, want.table_full, want.circle_count);
      $display(" got ok=%0d reason=%0d full=%0d count=%0d", got.placement_ok,
               got.fail_reason, got.table_full, got.circle_count);
    end
  endtask

  // --------------------------------------------------------------------
  // Monitor: output side checked before the input side is predicted, so a
  // stray result is never paired with an item taken on the same edge.
  // --------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    dpc_pkg::out_item_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          report_fault("result with nothing owed", '0, out_data);
        end else begin
          want = outcome_q.pop_front();
          if (want.placement_ok !== out_data.placement_ok ||
              want.fail_reason !== out_data.fail_reason ||
              want.table_full !== out_data.table_full ||
              want.circle_count !== out_data.circle_count)
            report_fault("result mismatch", want, out_data);
        end
      end
      if (in_valid && !in_stall)
        outcome_q.push_back(placement_outcome(in_data));
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog: too long without any transfer on either side
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb_disk_placement_checker_core: errors");
    $finish;
  end

  // --------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------
  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task automatic add_item(logic [1:0] op, int x, int y, int r, bit given);
    dpc_pkg::in_item_t it;
    it.opcode       = op;
    it.center_x     = x[dpc_pkg::COORD_W-1:0];
    it.center_y     = y[dpc_pkg::COORD_W-1:0];
    it.disk_radius  = r[dpc_pkg::RADIUS_W-1:0];
    it.radius_given = given;
    pending_items.push_back(it);
  endtask

  // sender holds off until the block has nothing in hand
  task automatic settle();
    while (pending_items.size() != 0 || in_valid || outcome_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write; only called while idle, so the bench copy moves at once
  task automatic write_reg(logic [dpc_pkg::CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[dpc_pkg::COORD_W-1:0];
    case (idx)
      dpc_pkg::REG_WALL_BOTTOM: cfg_bottom = longint'($signed(value[dpc_pkg::COORD_W-1:0]));
      dpc_pkg::REG_WALL_TOP:    cfg_top    = longint'($signed(value[dpc_pkg::COORD_W-1:0]));
      dpc_pkg::REG_GAP_MIN:     cfg_gap    = longint'(value[dpc_pkg::RADIUS_W-1:0]);
      dpc_pkg::REG_PERIOD_X:    cfg_period = longint'(value[dpc_pkg::PERIOD_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed traffic inside a window, with some pure noise and
  // probes placed at (or one below) the contact distance of the last insert.
  task automatic add_random(int n, int xr, int ylo, int yhi, int rmax);
    int roll, x, y, r, lim;
    bit g;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      x    = rand_between(-xr, xr);
      y    = rand_between(ylo, yhi);
      r    = $urandom_range(0, rmax);
      g    = 1'($urandom_range(0, 1));
      if (roll < 8) begin
        add_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, g);
      end else if (roll < 50) begin
        add_item(dpc_pkg::OP_QUERY, x, y, r, g);
      end else if (roll < 90) begin
        add_item(dpc_pkg::OP_INSERT, x, y, r, g);
        last_x = x;
        last_y = y;
        last_r = r;
        last_given = g;
      end else if (roll < 94) begin
        add_item(dpc_pkg::OP_CLEAR, x, y, r, g);
      end else if (roll < 96) begin
        add_item(OP_UNUSED, x, y, r, g);
      end else begin
        lim = r + (last_given ? last_r : r) + int'(cfg_gap);
        add_item(dpc_pkg::OP_QUERY, last_x + lim - int'($urandom_range(0, 1)), last_y, r, g);
      end
    end
  endtask

  // --------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------
  initial begin : stimulus
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset registers: both walls at zero, so only r=0 at y=0 clears them
    add_item(dpc_pkg::OP_QUERY, 0, 0, 0, 1'b0);         // empty table passes
    add_item(dpc_pkg::OP_QUERY, 0, -1, 0, 1'b0);        // bottom wall
    add_item(dpc_pkg::OP_QUERY, 0, 1, 0, 1'b0);         // top wall
    add_item(OP_UNUSED, 12345, -777, 99, 1'b1);
    add_item(dpc_pkg::OP_INSERT, 0, 0, 0, 1'b0);
    add_item(dpc_pkg::OP_QUERY, 0, 0, 0, 1'b0);         // zero limit, exact touch
    add_item(dpc_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    settle();

    // widest walls, no gap, not periodic
    write_reg(dpc_pkg::REG_WALL_BOTTOM, -8388608);
    write_reg(dpc_pkg::REG_WALL_TOP, 8388607);
    write_reg(dpc_pkg::REG_GAP_MIN, 0);
    write_reg(dpc_pkg::REG_PERIOD_X, 0);
    add_item(dpc_pkg::OP_INSERT, 8388607, -8388608, 1048575, 1'b1);
    add_item(dpc_pkg::OP_INSERT, -8388608, 8388607, 0, 1'b0);
    add_item(dpc_pkg::OP_QUERY, 0, 0, 0, 1'b0);
    add_item(dpc_pkg::OP_QUERY, 8388607, -8388608 + 1048575, 1048575, 1'b0);  // overlap
    add_item(dpc_pkg::OP_QUERY, 0, -8388608, 1, 1'b0);  // bottom at the extreme
    add_item(dpc_pkg::OP_QUERY, 0, 8388607, 1, 1'b0);   // top at the extreme
    add_item(dpc_pkg::OP_QUERY, 0, 8388607, 0, 1'b0);
    add_item(dpc_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    add_item(dpc_pkg::OP_INSERT, 1000, 0, 256, 1'b1);
    add_item(dpc_pkg::OP_QUERY, 1512, 0, 256, 1'b0);    // exactly touching
    add_item(dpc_pkg::OP_QUERY, 1511, 0, 256, 1'b0);    // one below contact
    add_item(dpc_pkg::OP_INSERT, 5000, 0, 999, 1'b0);   // radius missing: takes query's
    add_item(dpc_pkg::OP_QUERY, 5600, 0, 300, 1'b0);
    add_item(dpc_pkg::OP_QUERY, 5599, 0, 300, 1'b0);
    settle();

    // periodic, 64 cells, small gap
    write_reg(dpc_pkg::REG_PERIOD_X, 64);
    write_reg(dpc_pkg::REG_GAP_MIN, 16);
    add_item(dpc_pkg::OP_QUERY, 1000 + 16384 - 200, 0, 0, 1'b0);  // wraps down into overlap
    add_item(dpc_pkg::OP_QUERY, 1000 - 16384 + 300, 0, 0, 1'b0);  // wraps up, clear
    add_item(dpc_pkg::OP_QUERY, -8388608, 0, 0, 1'b0);            // still wide after one fold
    add_item(dpc_pkg::OP_QUERY, 0, -8388608 + 15, 0, 1'b0);       // gap pushes into bottom
    settle();

    // random, moderate walls
    write_reg(dpc_pkg::REG_WALL_BOTTOM, -8192);
    write_reg(dpc_pkg::REG_WALL_TOP, 8192);
    write_reg(dpc_pkg::REG_GAP_MIN, $urandom_range(0, 64));
    write_reg(dpc_pkg::REG_PERIOD_X, 0);
    add_random(75, 8192, -8500, 8500, 400);
    settle();
    add_random(75, 8192, -8500, 8500, 400);
    settle();

    // fill the table to the brim and beyond, smallest non-zero period
    write_reg(dpc_pkg::REG_GAP_MIN, 0);
    write_reg(dpc_pkg::REG_PERIOD_X, 1);
    add_item(dpc_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    repeat (TB_CIRCLES + 3)
      add_item(dpc_pkg::OP_INSERT, rand_between(-1048576, 1048576),
               rand_between(-8000, 8000), $urandom_range(0, 300),
               1'($urandom_range(0, 1)));
    add_random(10, 1048576, -8300, 8300, 300);
    settle();

    // random periodic domain, long stretch with no idling on either side
    write_reg(dpc_pkg::REG_PERIOD_X, $urandom_range(32, 96));
    write_reg(dpc_pkg::REG_GAP_MIN, $urandom_range(0, 128));
    write_reg(dpc_pkg::REG_WALL_BOTTOM, -rand_between(6000, 9000));
    write_reg(dpc_pkg::REG_WALL_TOP, rand_between(6000, 9000));
    steady = 1'b1;
    add_item(dpc_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    add_random(150, 20000, int'(cfg_bottom) - 300, int'(cfg_top) + 300, 400);
    settle();
    steady = 1'b0;

    // register extremes: largest period and gap, widest walls
    write_reg(dpc_pkg::REG_WALL_BOTTOM, -8388608);
    write_reg(dpc_pkg::REG_WALL_TOP, 8388607);
    write_reg(dpc_pkg::REG_GAP_MIN, 1048575);
    write_reg(dpc_pkg::REG_PERIOD_X, 32767);
    add_random(60, 8388607, -8388608, 8388607, 1048575);

    // drain, then let any stray result show itself
    while (pending_items.size() != 0 || in_valid || outcome_q.size() != 0)
      @(negedge clk);
    repeat (END_WAIT) @(negedge clk);
    if (fault_count == 0 && outcome_q.size() == 0)
      $display("tb_disk_placement_checker_core: clean");
    else
      $display("tb_disk_placement_checker_core: errors");
    $finish;
  end

endmodule
